/* sv/oscillator_waveform_mixer_top_assert.svh */
// Assertion macros for the oscillator waveform mixer checker.
// Expects clk and arst_n in scope at the point of use.
`ifndef OSCILLATOR_WAVEFORM_MIXER_TOP_ASSERT_SVH
`define OSCILLATOR_WAVEFORM_MIXER_TOP_ASSERT_SVH

// Plain property, sampled on clk, off while in reset.
`define OWM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("owm check failed");

// Implication: when ante holds, cons must hold (cons may carry a delay).
`define OWM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("owm implication failed");

`endif

/* sv/owm_pkg.sv */
// Shared types and constants for the oscillator waveform mixer.
// No dependencies; used by owm_wave and the top level.
`default_nettype none

package owm_pkg;

	localparam int OUT_W       = 17;	// sample and waveform width
	localparam int SUM_W       = 19;	// sum of five waveforms
	localparam int CNT_W       = 3;	// enabled waveform count, 0..5
	localparam int NUM_WAVES   = 5;
	localparam int RECIP_SHIFT = 22;
	localparam int RECIP_W     = 22;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int MODE_W      = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_EN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE = 2'd1;

	// enable bit positions
	localparam int EN_PULSE = 0;
	localparam int EN_SAW   = 1;
	localparam int EN_TRI   = 2;
	localparam int EN_NOISE = 3;
	localparam int EN_LFSR  = 4;

	// mix modes
	localparam logic [MODE_W-1:0] MIX_AND  = 3'd0;
	localparam logic [MODE_W-1:0] MIX_AVG  = 3'd1;
	localparam logic [MODE_W-1:0] MIX_OR   = 3'd2;
	localparam logic [MODE_W-1:0] MIX_CHIP = 3'd3;
	localparam logic [MODE_W-1:0] MIX_XOR  = 3'd4;

	// ceil(2^22/d): exact floor division for any 19-bit dividend
	localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'(((2**RECIP_SHIFT) + 1) / 2);
	localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((2**RECIP_SHIFT) + 2) / 3);
	localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(((2**RECIP_SHIFT) + 3) / 4);
	localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(((2**RECIP_SHIFT) + 4) / 5);

	localparam logic [CNT_W-1:0] CNT_0 = 3'd0;
	localparam logic [CNT_W-1:0] CNT_1 = 3'd1;
	localparam logic [CNT_W-1:0] CNT_2 = 3'd2;
	localparam logic [CNT_W-1:0] CNT_3 = 3'd3;
	localparam logic [CNT_W-1:0] CNT_4 = 3'd4;
	localparam logic [CNT_W-1:0] CNT_5 = 3'd5;

	// reductions over the enabled waveforms
	typedef struct packed {
		logic [OUT_W-1:0] and_v;
		logic [OUT_W-1:0] or_v;
		logic [OUT_W-1:0] xor_v;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} owm_red_t;

	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] r;
		unique case (cnt)
			CNT_2:   r = RECIP_2;
			CNT_3:   r = RECIP_3;
			CNT_4:   r = RECIP_4;
			CNT_5:   r = RECIP_5;
			default: r = '0;	// zero or one source: quotient unused
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/owm_wave.sv */
// Waveform generation and reduction (AND/OR/XOR/sum/count) for one item.
// Depends on owm_pkg.
`default_nettype none

module owm_wave #(
	parameter int PHASE_BITS  = 23,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic [PHASE_BITS-1:0]              phase,
	input  wire logic [12:0]                        pulse_width,
	input  wire logic [15:0]                        noise_word,
	input  wire logic [15:0]                        lfsr_word,
	input  wire logic [owm_pkg::NUM_WAVES-1:0]      wave_enables,
	output owm_pkg::owm_red_t                       red
);

	localparam logic [owm_pkg::OUT_W-1:0] FULL_SCALE =
		owm_pkg::OUT_W'((64'd1 << SAMPLE_BITS) - 64'd1);

	logic [16:0]               phase_top;
	logic [PHASE_BITS-1:0]     tri_src;
	logic [owm_pkg::OUT_W-1:0] wave [owm_pkg::NUM_WAVES];

	always_comb begin
		phase_top = phase[PHASE_BITS-1 -: 17];
		tri_src   = phase[PHASE_BITS-1] ? ~phase : phase;

		wave[owm_pkg::EN_PULSE] = (phase_top >= {pulse_width, 4'b0000}) ? FULL_SCALE : '0;
		wave[owm_pkg::EN_SAW]   = owm_pkg::OUT_W'(phase[PHASE_BITS-2 -: SAMPLE_BITS]);
		wave[owm_pkg::EN_TRI]   = owm_pkg::OUT_W'(tri_src[PHASE_BITS-2 -: SAMPLE_BITS+1]);
		wave[owm_pkg::EN_NOISE] = owm_pkg::OUT_W'(noise_word[SAMPLE_BITS-1:0]);
		wave[owm_pkg::EN_LFSR]  = owm_pkg::OUT_W'(lfsr_word);
	end

	always_comb begin
		red.and_v = '1;
		red.or_v  = '0;
		red.xor_v = '0;
		red.sum   = '0;
		red.cnt   = '0;
		for (int i = 0; i < owm_pkg::NUM_WAVES; i++) begin
			if (wave_enables[i]) begin
				red.and_v = red.and_v & wave[i];
				red.or_v  = red.or_v | wave[i];
				red.xor_v = red.xor_v ^ wave[i];
				red.sum   = red.sum + owm_pkg::SUM_W'(wave[i]);
				red.cnt   = red.cnt + owm_pkg::CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* sv/oscillator_waveform_mixer_top.sv */
// Oscillator waveform mixer: four-stage pipeline, one sample per item.
// Depends on owm_pkg and owm_wave.
//
// Use:
//   Input: drive phase, pulse_width, noise_word, lfsr_word and raise start.
//   The item is taken at a rising edge with start high and busy low; busy
//   never rises, so a new item may be taken on every cycle.
//   Output: sample is valid for exactly one cycle while done is high.
//   Throughput is one item per cycle. The stages are input register,
//   waveform/reduction, reciprocal multiply for the average, and the
//   final mode select.
//   Config: cfg_index 0 writes wave_enables (cfg_data[4:0]), index 1 writes
//   mix_mode (cfg_data[2:0]); other indexes are dropped. cfg_ready is
//   always high. Write only while no item is in flight.
//   Reset (arst_n low) clears both registers and all stage valid bits;
//   items in flight are dropped. The receiver cannot stall, so there is
//   no back-pressure path.
`default_nettype none

module oscillator_waveform_mixer_top #(
	parameter int PHASE_BITS  = 23,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output      logic                             busy,
	input  wire logic [PHASE_BITS-1:0]            phase,
	input  wire logic [12:0]                      pulse_width,
	input  wire logic [15:0]                      noise_word,
	input  wire logic [15:0]                      lfsr_word,
	output      logic                             done,
	output      logic [owm_pkg::OUT_W-1:0]        sample,
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [owm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [owm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam logic [owm_pkg::OUT_W-1:0] MID_SCALE =
		owm_pkg::OUT_W'(64'd1 << (SAMPLE_BITS - 1));
	localparam int PROD_W = owm_pkg::SUM_W + owm_pkg::RECIP_W;

	logic [owm_pkg::NUM_WAVES-1:0] wave_en_q;
	logic [owm_pkg::MODE_W-1:0]    mix_mode_q;

	// stage 1: input register
	logic                  valid_s1;
	logic [PHASE_BITS-1:0] phase_s1;
	logic [12:0]           pw_s1;
	logic [15:0]           noise_s1;
	logic [15:0]           lfsr_s1;

	// stage 2: reductions
	logic              valid_s2;
	owm_pkg::owm_red_t red_d;
	owm_pkg::owm_red_t red_s2;

	// stage 3: average product
	logic                       valid_s3;
	logic [PROD_W-1:0]          prod_s3;
	logic [owm_pkg::OUT_W-1:0]  and_s3;
	logic [owm_pkg::OUT_W-1:0]  or_s3;
	logic [owm_pkg::OUT_W-1:0]  xor_s3;
	logic [owm_pkg::CNT_W-1:0]  cnt_s3;

	// stage 4: output
	logic                       valid_s4;
	logic [owm_pkg::OUT_W-1:0]  sample_s4;
	logic [owm_pkg::OUT_W-1:0]  result;
	logic [owm_pkg::OUT_W-1:0]  avg;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_en_q  <= '0;
			mix_mode_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == owm_pkg::REG_WAVE_EN) begin
				wave_en_q <= cfg_data[owm_pkg::NUM_WAVES-1:0];
			end else if (cfg_index == owm_pkg::REG_MIX_MODE) begin
				mix_mode_q <= cfg_data[owm_pkg::MODE_W-1:0];
			end
		end
	end

	owm_wave #(
		.PHASE_BITS  (PHASE_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_wave (
		.phase        (phase_s1),
		.pulse_width  (pw_s1),
		.noise_word   (noise_s1),
		.lfsr_word    (lfsr_s1),
		.wave_enables (wave_en_q),
		.red          (red_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		phase_s1 <= phase;
		pw_s1    <= pulse_width;
		noise_s1 <= noise_word;
		lfsr_s1  <= lfsr_word;

		red_s2 <= red_d;

		prod_s3 <= {{owm_pkg::RECIP_W{1'b0}}, red_s2.sum}
			* {{owm_pkg::SUM_W{1'b0}}, owm_pkg::recip(red_s2.cnt)};
		and_s3  <= red_s2.and_v;
		or_s3   <= red_s2.or_v;
		xor_s3  <= red_s2.xor_v;
		cnt_s3  <= red_s2.cnt;

		sample_s4 <= result;
	end

	assign avg = prod_s3[owm_pkg::RECIP_SHIFT +: owm_pkg::OUT_W];

	always_comb begin
		priority if (cnt_s3 == owm_pkg::CNT_0) begin
			result = MID_SCALE;
		end else if (cnt_s3 == owm_pkg::CNT_1) begin
			result = or_s3;	// single source passes as is
		end else begin
			unique case (mix_mode_q)
				owm_pkg::MIX_AND,
				owm_pkg::MIX_CHIP: result = and_s3;
				owm_pkg::MIX_AVG:  result = avg;
				owm_pkg::MIX_OR:   result = or_s3;
				owm_pkg::MIX_XOR:  result = xor_s3;
				default:           result = MID_SCALE;
			endcase
		end
	end

	assign done   = valid_s4;
	assign sample = sample_s4;

endmodule

`default_nettype wire

/* sv/owm_checker.sv */
// Port-level checks for the oscillator waveform mixer, bound to the top level.
// Depends on oscillator_waveform_mixer_top_assert.svh.
`default_nettype none

`include "oscillator_waveform_mixer_top_assert.svh"

module owm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic cfg_valid,
	input wire logic cfg_ready
);

	// every taken item gives its beat once it has passed through the pipeline
	`OWM_ASSERT_IMPL(a_item_to_beat, start && !busy, ##4 done)

	// no beat without an item taken earlier
	`OWM_ASSERT_IMPL(a_beat_from_item, done, $past(start && !busy, 4))

	// config writes are never held off
	`OWM_ASSERT_IMPL(a_cfg_taken, cfg_valid, cfg_ready)

endmodule

bind oscillator_waveform_mixer_top owm_checker u_owm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire

/* dv/owm_sample_checker.sv */
// Checker for the oscillator waveform mixer: predicts each sample from the accepted beat and
// the current register settings, and compares it with the strobed output. Depends on owm_pkg.
`timescale 1ns / 100ps

module owm_sample_checker
	import owm_pkg::*;
#(
	parameter int PHASE_BITS  = 23,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [PHASE_BITS-1:0] phase,
	input  logic [12:0]           pulse_width,
	input  logic [15:0]           noise_word,
	input  logic [15:0]           lfsr_word,
	input  logic                  done,
	input  logic [OUT_W-1:0]      sample,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	localparam logic [31:0] WAVE_MAX  = (32'd1 << SAMPLE_BITS) - 32'd1;
	localparam logic [31:0] TRI_MASK  = (32'd1 << (SAMPLE_BITS + 1)) - 32'd1;
	localparam logic [31:0] MID_SCALE = 32'd1 << (SAMPLE_BITS - 1);

	logic [NUM_WAVES-1:0] wave_on;
	logic [MODE_W-1:0]    mix_sel;
	logic [OUT_W-1:0]     expected_samples[$];

	initial mismatches = 0;

	function automatic logic [OUT_W-1:0] mixed_sample(input logic [PHASE_BITS-1:0] ph,
			input logic [12:0] pw, input logic [15:0] nw, input logic [15:0] lw);
		logic [31:0] acc;
		logic [31:0] folded;
		logic [31:0] wave[NUM_WAVES];
		logic [31:0] and_v, or_v, xor_v, sum, count, result;
		acc = 32'(ph);
		wave[EN_PULSE] = ((acc >> (PHASE_BITS - 17)) >= (32'(pw) << 4)) ? WAVE_MAX : 32'd0;
		wave[EN_SAW]   = (acc >> (PHASE_BITS - SAMPLE_BITS - 1)) & WAVE_MAX;
		// triangle folds on the top phase bit by inverting the whole word
		folded         = acc[PHASE_BITS-1] ? ~acc : acc;
		wave[EN_TRI]   = (folded >> (PHASE_BITS - SAMPLE_BITS - 2)) & TRI_MASK;
		wave[EN_NOISE] = 32'(nw) & WAVE_MAX;
		wave[EN_LFSR]  = 32'(lw);
		and_v = '1;
		or_v  = '0;
		xor_v = '0;
		sum   = '0;
		count = '0;
		for (int i = 0; i < NUM_WAVES; i++) begin
			if (wave_on[i]) begin
				and_v &= wave[i];
				or_v  |= wave[i];
				xor_v ^= wave[i];
				sum   += wave[i];
				count++;
			end
		end
		if (count == 0) begin
			result = MID_SCALE;
		end else if (count == 1) begin
			result = or_v;
		end else begin
			case (mix_sel)
				MIX_AND, MIX_CHIP: result = and_v;
				MIX_AVG:           result = sum / count;
				MIX_OR:            result = or_v;
				MIX_XOR:           result = xor_v;
				default:           result = MID_SCALE;
			endcase
		end
		return OUT_W'(result);
	endfunction

	task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		$display("%0t: %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_on <= '0;
			mix_sel <= MIX_AND;
			expected_samples.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				if (expected_samples.size() == 0) begin
					report_mismatch("sample with nothing expected", sample, '0);
				end else begin
					if (sample !== expected_samples[0])
						report_mismatch("sample mismatch", sample, expected_samples[0]);
					void'(expected_samples.pop_front());
				end
			end
			if (start && !busy)
				expected_samples.push_back(mixed_sample(phase, pulse_width, noise_word, lfsr_word));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WAVE_EN:  wave_on <= cfg_data[NUM_WAVES-1:0];
					REG_MIX_MODE: mix_sel <= cfg_data[MODE_W-1:0];
					default:      ;	// spare indexes are dropped
				endcase
			end
			outstanding <= expected_samples.size();
		end
	end

endmodule

/* dv/tb_oscillator_waveform_mixer_top.sv */
// Testbench top for oscillator_waveform_mixer_top: clock, reset, register writes and item
// stimulus with random gaps. Checking lives in owm_sample_checker; depends on owm_pkg.
`timescale 1ns / 100ps

module tb_oscillator_waveform_mixer_top;

	import owm_pkg::*;

	localparam int PHASE_BITS  = 23;
	localparam int SAMPLE_BITS = 16;
	localparam int FLUSH_CYCLES = 6;	// pipeline is four deep
	localparam int PHASES       = 64;
	localparam int PHASE_ITEMS  = 27;

	// undefined mix modes and unused register indexes
	localparam logic [MODE_W-1:0]    MIX_UNDEF_MIN = 3'd5;
	localparam logic [MODE_W-1:0]    MIX_UNDEF_MAX = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [PHASE_BITS-1:0] phase;
	logic [12:0] pulse_width;
	logic [15:0] noise_word;
	logic [15:0] lfsr_word;
	logic done;
	logic [OUT_W-1:0] sample;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int mismatches;
	int outstanding;
	bit gaps_on = 1'b1;

	always #5 clk = ~clk;

	oscillator_waveform_mixer_top #(
		.PHASE_BITS(PHASE_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.phase(phase),
		.pulse_width(pulse_width),
		.noise_word(noise_word),
		.lfsr_word(lfsr_word),
		.done(done),
		.sample(sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	owm_sample_checker #(
		.PHASE_BITS(PHASE_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.phase(phase),
		.pulse_width(pulse_width),
		.noise_word(noise_word),
		.lfsr_word(lfsr_word),
		.done(done),
		.sample(sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	task automatic send_item(input logic [PHASE_BITS-1:0] ph, input logic [12:0] pw,
			input logic [15:0] nw, input logic [15:0] lw);
		start       <= 1'b1;
		phase       <= ph;
		pulse_width <= pw;
		noise_word  <= nw;
		lfsr_word   <= lw;
		do @(posedge clk); while (busy);
		if (gaps_on && $urandom_range(0, 99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_random_item();
		logic [PHASE_BITS-1:0] ph;
		logic [12:0] pw;
		logic [15:0] nw, lw;
		ph = PHASE_BITS'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0:       ph = '0;
				1:       ph = '1;
				2:       ph = {1'b1, {(PHASE_BITS-1){1'b0}}};
				default: ph = {1'b0, {(PHASE_BITS-1){1'b1}}};
			endcase
		end
		case ($urandom_range(0, 9))
			// land the width right at the pulse edge: one below, on, one above
			0, 1, 2, 3: pw = 13'(ph >> (PHASE_BITS - 13)) + 13'($urandom_range(0, 2)) - 13'd1;
			4:          pw = $urandom_range(0, 1) ? '0 : '1;
			default:    pw = 13'($urandom);
		endcase
		nw = 16'($urandom);
		lw = 16'($urandom);
		if ($urandom_range(0, 9) == 0) nw = $urandom_range(0, 1) ? '0 : '1;
		if ($urandom_range(0, 9) == 0) lw = $urandom_range(0, 1) ? '0 : '1;
		send_item(ph, pw, nw, lw);
	endtask

	// hold off until every sample is back and the pipeline has emptied
	task automatic quiesce();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	// valid is dropped after each write, so back-to-back writes never hold it high throughout
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [PHASE_BITS-1:0] edge_ph;
		logic [NUM_WAVES-1:0] en;
		logic [MODE_W-1:0] md;
		int n;
		arst_n      = 1'b0;
		start       <= 1'b0;
		phase       <= '0;
		pulse_width <= '0;
		noise_word  <= '0;
		lfsr_word   <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes with every waveform in the average
		write_reg(REG_WAVE_EN, '1);
		write_reg(REG_MIX_MODE, CFG_DATA_W'(MIX_AVG));
		send_item('0, '0, '0, '0);
		send_item('1, '1, '1, '1);
		send_item({1'b1, {(PHASE_BITS-1){1'b0}}}, '0, 16'hAAAA, 16'h5555);
		send_item({1'b0, {(PHASE_BITS-1){1'b1}}}, '1, 16'h5555, 16'hAAAA);
		edge_ph = 23'h5A5A5A;
		send_item(edge_ph, 13'(edge_ph >> (PHASE_BITS - 13)), 16'h1234, 16'hFEDC);
		send_item(edge_ph, 13'(edge_ph >> (PHASE_BITS - 13)) + 13'd1, 16'h1234, 16'hFEDC);

		// every mix mode, defined or not
		for (int m = 0; m < 8; m++) begin
			quiesce();
			write_reg(REG_MIX_MODE, CFG_DATA_W'(m));
			send_random_item();
		end

		// nothing enabled gives mid-scale
		quiesce();
		write_reg(REG_WAVE_EN, '0);
		send_random_item();
		// one source under an undefined mode passes straight through
		quiesce();
		write_reg(REG_WAVE_EN, CFG_DATA_W'(1 << EN_TRI));
		write_reg(REG_MIX_MODE, CFG_DATA_W'(MIX_UNDEF_MAX));
		send_random_item();
		// two sources under an undefined mode
		quiesce();
		write_reg(REG_WAVE_EN, CFG_DATA_W'((1 << EN_PULSE) | (1 << EN_SAW)));
		write_reg(REG_MIX_MODE, CFG_DATA_W'(MIX_UNDEF_MIN));
		send_random_item();
		// spare index must not disturb the registers
		quiesce();
		write_reg(REG_SPARE_LO, '1);
		send_random_item();

		for (int p = 0; p < PHASES; p++) begin
			quiesce();
			en = NUM_WAVES'($urandom);
			md = MODE_W'($urandom_range(0, 7));
			if (p == 0) begin
				en = '1;
				md = MIX_UNDEF_MAX;
			end else if (p == 1) begin
				en = '0;
				md = MIX_AND;
			end
			write_reg(REG_WAVE_EN, CFG_DATA_W'(en));
			write_reg(REG_MIX_MODE, CFG_DATA_W'({(CFG_DATA_W-MODE_W)'($urandom), md}));
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
					CFG_DATA_W'($urandom));
			gaps_on = !(p >= 20 && p < 30);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_random_item();
				if (p % 16 == 5 && i == PHASE_ITEMS / 2)
					quiesce();
			end
		end

		start <= 1'b0;
		n = 0;
		do begin
			@(posedge clk);
			n++;
		end while (outstanding != 0 && n < 200);
		repeat (FLUSH_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("oscillator_waveform_mixer_top verification clean");
		else
			$display("oscillator_waveform_mixer_top verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("oscillator_waveform_mixer_top verification failed");
		$finish;
	end

endmodule
